@@ rtl/core/tthc_pkg.sv @@
// Package for the touch tap/hold classifier.
// Holds register defaults, register indexes, event codes and shared types.
// No dependencies.
`default_nettype none

package tthc_pkg;

    localparam int DEF_TIME_WIDTH = 32;
    localparam int CFG_WIDTH      = 16;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int OUT_TIME_WIDTH = 32;
    localparam int IN_TIME_WIDTH  = 32;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_WIDTH-1:0] TAP_MAX_RESET  = 16'd300;
    localparam logic [CFG_WIDTH-1:0] HOLD_MIN_RESET = 16'd1000;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_DEBOUNCE    = 2'd0,
        REG_TAP_MAX     = 2'd1,
        REG_HOLD_MIN    = 2'd2,
        REG_CHIN_ENABLE = 2'd3
    } tthc_reg_idx_t;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_TAP        = 3'd1,
        EV_HOLD_START = 3'd2,
        EV_HOLDING    = 3'd3,
        EV_HOLD_END   = 3'd4
    } tthc_event_t;

    // per-channel decode of one sample
    typedef struct packed {
        logic level_next;    // debounced level after the sample
        logic press;         // accepted rising change
        logic release_;      // accepted falling change
        logic short_press;   // press time below tap limit
        logic hold_reached;  // stable pressed and past hold minimum
        logic held;          // pressed after sample and hold time >= hold minimum
    } tthc_chan_t;

endpackage

`default_nettype wire

@@ rtl/core/tthc_channel.sv @@
// Debounce and press-timing logic for one touch channel, purely combinational.
// Depends on tthc_pkg.
`default_nettype none

module tthc_channel #(
    parameter int TIME_WIDTH = tthc_pkg::DEF_TIME_WIDTH
) (
    input  wire logic [TIME_WIDTH-1:0]                now,
    input  wire logic                                 raw,
    input  wire logic                                 level,
    input  wire logic [TIME_WIDTH-1:0]                agree_stamp,
    input  wire logic [TIME_WIDTH-1:0]                press_stamp,
    input  wire logic [tthc_pkg::CFG_WIDTH-1:0]       debounce,
    input  wire logic [tthc_pkg::CFG_WIDTH-1:0]       tap_max,
    input  wire logic [tthc_pkg::CFG_WIDTH-1:0]       hold_min,
    output tthc_pkg::tthc_chan_t                      st,
    output logic [TIME_WIDTH-1:0]                     agree_next,
    output logic [TIME_WIDTH-1:0]                     press_next,
    output logic [tthc_pkg::OUT_TIME_WIDTH-1:0]       hold_time
);

    logic [TIME_WIDTH-1:0] since_agree;
    logic [TIME_WIDTH-1:0] since_press;
    logic [TIME_WIDTH-1:0] held_for;
    logic [TIME_WIDTH+tthc_pkg::CFG_WIDTH-1:0] deb_w;
    logic [TIME_WIDTH+tthc_pkg::CFG_WIDTH-1:0] tap_w;
    logic [TIME_WIDTH+tthc_pkg::CFG_WIDTH-1:0] hold_w;
    logic [TIME_WIDTH+tthc_pkg::OUT_TIME_WIDTH-1:0] held_w;
    logic differs;
    logic accept_chg;

    assign since_agree = now - agree_stamp;
    assign since_press = now - press_stamp;
    assign deb_w  = {{TIME_WIDTH{1'b0}}, debounce};
    assign tap_w  = {{TIME_WIDTH{1'b0}}, tap_max};
    assign hold_w = {{TIME_WIDTH{1'b0}}, hold_min};

    assign differs    = raw != level;
    assign accept_chg = differs && (since_agree >= deb_w[TIME_WIDTH-1:0]);

    assign agree_next = (!differs || accept_chg) ? now : agree_stamp;
    assign press_next = (accept_chg && raw) ? now : press_stamp;

    // a fresh press reads as zero time
    assign held_for = (level && !accept_chg) ? since_press : '0;
    assign held_w   = {{tthc_pkg::OUT_TIME_WIDTH{1'b0}}, held_for};
    assign hold_time = held_w[tthc_pkg::OUT_TIME_WIDTH-1:0];

    always_comb
    begin
        st.level_next   = accept_chg ? raw : level;
        st.press        = accept_chg && raw;
        st.release_     = accept_chg && !raw;
        st.short_press  = since_press < tap_w[TIME_WIDTH-1:0];
        st.hold_reached = !differs && level && (since_press >= hold_w[TIME_WIDTH-1:0]);
        st.held         = st.level_next && (held_for >= hold_w[TIME_WIDTH-1:0]);
    end

endmodule

`default_nettype wire

@@ rtl/core/touch_tap_hold_classifier.sv @@
// Touch tap/hold classifier top level: config registers, input word register,
// channel state and result word register. Depends on tthc_pkg, tthc_channel.
//
// Usage:
// - Input channel (in_valid/in_ready) carries one sample word: now_ms,
//   head_raw, chin_raw. Output channel (out_valid/out_ready) carries one
//   result word per sample, in order.
// - Config port: cfg_we with cfg_index/cfg_data writes one register per
//   cycle; write only while no word is in flight.
// - Path: an accepted word passes through the input register, then the
//   result register.
// - Throughput: one word per cycle while out_ready is high. Debounce and
//   classify logic sit in one combinational pass between both registers.
// - Stall: while out_ready is low the result word holds, the input register
//   keeps its word and in_ready falls once both are full; nothing is lost.
// - Reset: registers return to their defaults (debounce 50, tap 300,
//   hold 1000, chin off), all channel state clears, both channels go empty.
// - Chin disabled: chin state is frozen and all chin result fields are 0.
`default_nettype none

module touch_tap_hold_classifier #(
    parameter int TIME_WIDTH = tthc_pkg::DEF_TIME_WIDTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [tthc_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  wire logic [tthc_pkg::CFG_WIDTH-1:0]        cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [tthc_pkg::IN_TIME_WIDTH-1:0]    now_ms,
    input  wire logic                                  head_raw,
    input  wire logic                                  chin_raw,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [2:0]                                 head_event,
    output logic [2:0]                                 chin_event,
    output logic                                       head_pressed,
    output logic                                       chin_pressed,
    output logic                                       head_held,
    output logic                                       chin_held,
    output logic [tthc_pkg::OUT_TIME_WIDTH-1:0]        head_hold_time,
    output logic [tthc_pkg::OUT_TIME_WIDTH-1:0]        chin_hold_time
);

    localparam int OW = tthc_pkg::OUT_TIME_WIDTH;

    // config
    logic [tthc_pkg::CFG_WIDTH-1:0] debounce_reg;
    logic [tthc_pkg::CFG_WIDTH-1:0] tap_max_reg;
    logic [tthc_pkg::CFG_WIDTH-1:0] hold_min_reg;
    logic                           chin_en_reg;

    // input word
    logic                  in_v_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  head_raw_reg;
    logic                  chin_raw_reg;
    logic [TIME_WIDTH+tthc_pkg::IN_TIME_WIDTH-1:0] now_wide;

    // channel state
    logic                  head_level_reg, head_level_next;
    logic [TIME_WIDTH-1:0] head_agree_reg, head_agree_next;
    logic [TIME_WIDTH-1:0] head_press_reg, head_press_next;
    logic                  head_sent_reg, head_sent_next;
    logic                  chin_level_reg, chin_level_next;
    logic [TIME_WIDTH-1:0] chin_agree_reg, chin_agree_next;
    logic [TIME_WIDTH-1:0] chin_press_reg, chin_press_next;
    tthc_pkg::tthc_event_t chin_ev_reg, chin_ev_next;

    // result word
    logic                  out_v_reg;
    tthc_pkg::tthc_event_t head_ev_out_reg, head_ev_next;
    logic [2:0]            chin_ev_out_reg;
    logic                  head_pr_reg, chin_pr_reg, head_hd_reg, chin_hd_reg;
    logic [OW-1:0]         head_ht_reg, chin_ht_reg;

    tthc_pkg::tthc_chan_t  head_st, chin_st;
    logic [TIME_WIDTH-1:0] head_agree_c, head_press_c, chin_agree_c, chin_press_c;
    logic [OW-1:0]         head_ht_c, chin_ht_c;
    logic                  advance;

    assign advance  = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready = !in_v_reg || advance;
    assign now_wide = {{TIME_WIDTH{1'b0}}, now_ms};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= tthc_pkg::DEBOUNCE_RESET;
            tap_max_reg  <= tthc_pkg::TAP_MAX_RESET;
            hold_min_reg <= tthc_pkg::HOLD_MIN_RESET;
            chin_en_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (tthc_pkg::tthc_reg_idx_t'(cfg_index))
                tthc_pkg::REG_DEBOUNCE:    debounce_reg <= cfg_data;
                tthc_pkg::REG_TAP_MAX:     tap_max_reg  <= cfg_data;
                tthc_pkg::REG_HOLD_MIN:    hold_min_reg <= cfg_data;
                tthc_pkg::REG_CHIN_ENABLE: chin_en_reg  <= cfg_data[0];
                default:                   chin_en_reg  <= chin_en_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            now_reg      <= now_wide[TIME_WIDTH-1:0];
            head_raw_reg <= head_raw;
            chin_raw_reg <= chin_raw;
        end
    end

    tthc_channel #(.TIME_WIDTH(TIME_WIDTH)) u_head (
        .now         (now_reg),
        .raw         (head_raw_reg),
        .level       (head_level_reg),
        .agree_stamp (head_agree_reg),
        .press_stamp (head_press_reg),
        .debounce    (debounce_reg),
        .tap_max     (tap_max_reg),
        .hold_min    (hold_min_reg),
        .st          (head_st),
        .agree_next  (head_agree_c),
        .press_next  (head_press_c),
        .hold_time   (head_ht_c)
    );

    tthc_channel #(.TIME_WIDTH(TIME_WIDTH)) u_chin (
        .now         (now_reg),
        .raw         (chin_raw_reg),
        .level       (chin_level_reg),
        .agree_stamp (chin_agree_reg),
        .press_stamp (chin_press_reg),
        .debounce    (debounce_reg),
        .tap_max     (tap_max_reg),
        .hold_min    (hold_min_reg),
        .st          (chin_st),
        .agree_next  (chin_agree_c),
        .press_next  (chin_press_c),
        .hold_time   (chin_ht_c)
    );

    // head classification
    always_comb
    begin
        head_level_next = head_st.level_next;
        head_agree_next = head_agree_c;
        head_press_next = head_press_c;
        head_sent_next  = head_sent_reg;
        head_ev_next    = tthc_pkg::EV_NONE;
        if (head_st.press)
        begin
            head_sent_next = 1'b0;
        end
        else if (head_st.release_)
        begin
            head_sent_next = 1'b0;
            head_ev_next   = head_st.short_press ? tthc_pkg::EV_TAP : tthc_pkg::EV_HOLD_END;
        end
        else if (head_st.hold_reached)
        begin
            head_sent_next = 1'b1;
            head_ev_next   = head_sent_reg ? tthc_pkg::EV_HOLDING : tthc_pkg::EV_HOLD_START;
        end
    end

    // chin classification, frozen when disabled
    always_comb
    begin
        chin_level_next = chin_level_reg;
        chin_agree_next = chin_agree_reg;
        chin_press_next = chin_press_reg;
        chin_ev_next    = chin_ev_reg;
        if (chin_en_reg)
        begin
            chin_level_next = chin_st.level_next;
            chin_agree_next = chin_agree_c;
            chin_press_next = chin_press_c;
            if (chin_st.press)
                chin_ev_next = tthc_pkg::EV_HOLD_START;
            else if (chin_st.release_)
                chin_ev_next = chin_st.short_press ? tthc_pkg::EV_TAP
                                                   : tthc_pkg::EV_HOLD_END;
            else if (chin_raw_reg == chin_level_reg)
            begin
                if (!chin_level_reg)
                    chin_ev_next = tthc_pkg::EV_NONE;
                else if (chin_st.hold_reached)
                    chin_ev_next = tthc_pkg::EV_HOLDING;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_level_reg <= 1'b0;
            head_agree_reg <= '0;
            head_press_reg <= '0;
            head_sent_reg  <= 1'b0;
            chin_level_reg <= 1'b0;
            chin_agree_reg <= '0;
            chin_press_reg <= '0;
            chin_ev_reg    <= tthc_pkg::EV_NONE;
        end
        else if (advance)
        begin
            head_level_reg <= head_level_next;
            head_agree_reg <= head_agree_next;
            head_press_reg <= head_press_next;
            head_sent_reg  <= head_sent_next;
            chin_level_reg <= chin_level_next;
            chin_agree_reg <= chin_agree_next;
            chin_press_reg <= chin_press_next;
            chin_ev_reg    <= chin_ev_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_v_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            head_ev_out_reg <= head_ev_next;
            chin_ev_out_reg <= chin_en_reg ? chin_ev_next : tthc_pkg::EV_NONE;
            head_pr_reg     <= head_st.level_next;
            chin_pr_reg     <= chin_en_reg && chin_st.level_next;
            head_hd_reg     <= head_st.held;
            chin_hd_reg     <= chin_en_reg && chin_st.held;
            head_ht_reg     <= head_ht_c;
            chin_ht_reg     <= chin_en_reg ? chin_ht_c : '0;
        end
    end

    assign out_valid      = out_v_reg;
    assign head_event     = head_ev_out_reg;
    assign chin_event     = chin_ev_out_reg;
    assign head_pressed   = head_pr_reg;
    assign chin_pressed   = chin_pr_reg;
    assign head_held      = head_hd_reg;
    assign chin_held      = chin_hd_reg;
    assign head_hold_time = head_ht_reg;
    assign chin_hold_time = chin_ht_reg;

endmodule

`default_nettype wire

@@ rtl/core/tthc_checker.sv @@
// Port-level checks for the touch tap/hold classifier, bound to the top level.
// Depends on tthc_pkg and touch_tap_hold_classifier.
`default_nettype none

module tthc_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 out_valid,
    input wire logic                                 out_ready,
    input wire logic [2:0]                           head_event,
    input wire logic                                 head_pressed,
    input wire logic                                 chin_pressed,
    input wire logic                                 head_held,
    input wire logic                                 chin_held,
    input wire logic [tthc_pkg::OUT_TIME_WIDTH-1:0]  head_hold_time,
    input wire logic [tthc_pkg::OUT_TIME_WIDTH-1:0]  chin_hold_time
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_released_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !head_pressed |-> head_hold_time == '0 && !head_held)
        else $error("head released but hold time or held set");

    a_chin_released_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !chin_pressed |-> chin_hold_time == '0 && !chin_held)
        else $error("chin released but hold time or held set");

    a_release_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (head_event == tthc_pkg::EV_TAP || head_event == tthc_pkg::EV_HOLD_END)
        |-> !head_pressed)
        else $error("head release event while pressed");

    a_hold_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (head_event == tthc_pkg::EV_HOLD_START
                      || head_event == tthc_pkg::EV_HOLDING)
        |-> head_pressed && head_held)
        else $error("head hold event without held press");

endmodule

bind touch_tap_hold_classifier tthc_checker u_tthc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .head_event     (head_event),
    .head_pressed   (head_pressed),
    .chin_pressed   (chin_pressed),
    .head_held      (head_held),
    .chin_held      (chin_held),
    .head_hold_time (head_hold_time),
    .chin_hold_time (chin_hold_time)
);

`default_nettype wire

@@ test/tb_touch_tap_hold_classifier.sv @@
// Testbench for touch_tap_hold_classifier: a directed table of samples, then
// random touch sequences under random register settings and random stalls.
// Depends on tthc_pkg and the classifier RTL; every result word is checked.
module tb_touch_tap_hold_classifier;

    import tthc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_WORDS = 212;
    localparam int LONG_STALL  = 600;

    typedef struct packed {
        tthc_event_t head_ev;
        tthc_event_t chin_ev;
        logic        head_pr;
        logic        chin_pr;
        logic        head_hd;
        logic        chin_hd;
        logic [31:0] head_t;
        logic [31:0] chin_t;
    } touch_report_t;

    typedef struct packed {
        logic          cfg;
        logic [15:0]   deb;
        logic [15:0]   tap;
        logic [15:0]   hold;
        logic          chin_en;
        logic [31:0]   now;
        logic          head;
        logic          chin;
        logic          typed;
        touch_report_t want;
    } sample_row_t;

    localparam sample_row_t DIRECTED_ROWS [26] = '{
        // reset settings: debounce 50, tap 300, hold 1000, chin off
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1,
          '{EV_NONE, EV_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd10, 1'b1, 1'b0, 1'b1,
          '{EV_NONE, EV_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd60, 1'b1, 1'b0, 1'b1,
          '{EV_NONE, EV_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd160, 1'b0, 1'b0, 1'b1,
          '{EV_TAP, EV_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd200, 1'b1, 1'b0, 1'b1,
          '{EV_NONE, EV_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd210, 1'b1, 1'b0, 1'b1,
          '{EV_NONE, EV_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd1210, 1'b1, 1'b0, 1'b1,
          '{EV_HOLD_START, EV_NONE, 1'b1, 1'b0, 1'b1, 1'b0, 32'd1000, 32'd0}},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd1300, 1'b1, 1'b0, 1'b1,
          '{EV_HOLDING, EV_NONE, 1'b1, 1'b0, 1'b1, 1'b0, 32'd1090, 32'd0}},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd1350, 1'b0, 1'b0, 1'b1,
          '{EV_HOLD_END, EV_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
        // press across the wrap of the time stamp
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'h0000_0010, 1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'h0000_0100, 1'b0, 1'b0, 1'b0, '0},
        // chin on: debounce 20, tap 100, hold 500
        '{1'b1, 16'd20, 16'd100, 16'd500, 1'b1, 32'h200, 1'b0, 1'b0, 1'b1,
          '{EV_NONE, EV_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'h210, 1'b0, 1'b1, 1'b1,
          '{EV_NONE, EV_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'h220, 1'b0, 1'b1, 1'b1,
          '{EV_NONE, EV_HOLD_START, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0}},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'h414, 1'b0, 1'b1, 1'b1,
          '{EV_NONE, EV_HOLDING, 1'b0, 1'b1, 1'b0, 1'b1, 32'd0, 32'd500}},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'h500, 1'b0, 1'b0, 1'b1,
          '{EV_NONE, EV_HOLD_END, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'h540, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'h560, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'h5A0, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'h5B0, 1'b1, 1'b1, 1'b0, '0},
        // all limits at zero, chin frozen
        '{1'b1, 16'd0, 16'd0, 16'd0, 1'b0, 32'h600, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'h600, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'h601, 1'b0, 1'b1, 1'b0, '0},
        // all limits at maximum, chin resumes
        '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'h700, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'h106FF, 1'b1, 1'b1, 1'b0, '0}
    };

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]     cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [IN_TIME_WIDTH-1:0] now_ms    = '0;
    logic                     head_raw  = 1'b0;
    logic                     chin_raw  = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [2:0]               head_event;
    logic [2:0]               chin_event;
    logic                     head_pressed;
    logic                     chin_pressed;
    logic                     head_held;
    logic                     chin_held;
    logic [OUT_TIME_WIDTH-1:0] head_hold_time;
    logic [OUT_TIME_WIDTH-1:0] chin_hold_time;

    // predictor copy of registers and channel state
    logic [15:0] debounce_cfg = DEBOUNCE_RESET;
    logic [15:0] tap_cfg      = TAP_MAX_RESET;
    logic [15:0] hold_cfg     = HOLD_MIN_RESET;
    logic        chin_cfg     = 1'b0;
    logic        head_lvl     = 1'b0;
    logic        head_start_sent = 1'b0;
    logic [31:0] head_agree   = '0;
    logic [31:0] head_press   = '0;
    logic        chin_lvl     = 1'b0;
    logic [31:0] chin_agree   = '0;
    logic [31:0] chin_press   = '0;
    tthc_event_t chin_sticky  = EV_NONE;

    touch_report_t expected_reports[$];
    int errors       = 0;
    int results_seen = 0;

    touch_tap_hold_classifier dut (.*);

    always #5 clk = ~clk;

    function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] stamp);
        return now - stamp;
    endfunction

    function automatic touch_report_t classify_sample(input logic [31:0] now, input logic h,
                                                      input logic c);
        touch_report_t r;
        r = '0;
        if (h != head_lvl)
        begin
            if (since(now, head_agree) >= debounce_cfg)
            begin
                head_lvl   = h;
                head_agree = now;
                if (h)
                    head_press = now;
                else
                    r.head_ev = (since(now, head_press) < tap_cfg) ? EV_TAP : EV_HOLD_END;
                head_start_sent = 1'b0;
            end
        end
        else
        begin
            head_agree = now;
            if (head_lvl && since(now, head_press) >= hold_cfg)
            begin
                r.head_ev       = head_start_sent ? EV_HOLDING : EV_HOLD_START;
                head_start_sent = 1'b1;
            end
        end
        if (chin_cfg)
        begin
            if (c != chin_lvl)
            begin
                if (since(now, chin_agree) >= debounce_cfg)
                begin
                    chin_lvl   = c;
                    chin_agree = now;
                    if (c)
                    begin
                        chin_press  = now;
                        chin_sticky = EV_HOLD_START;
                    end
                    else
                        chin_sticky = (since(now, chin_press) < tap_cfg) ? EV_TAP : EV_HOLD_END;
                end
            end
            else
            begin
                chin_agree = now;
                if (!chin_lvl)
                    chin_sticky = EV_NONE;
                else if (since(now, chin_press) >= hold_cfg)
                    chin_sticky = EV_HOLDING;
            end
            r.chin_ev = chin_sticky;
            r.chin_pr = chin_lvl;
            if (chin_lvl)
                r.chin_t = since(now, chin_press);
            r.chin_hd = chin_lvl && r.chin_t >= hold_cfg;
        end
        r.head_pr = head_lvl;
        if (head_lvl)
            r.head_t = since(now, head_press);
        r.head_hd = head_lvl && r.head_t >= hold_cfg;
        return r;
    endfunction

    function automatic int next_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_limit(input int spread);
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, spread));
    endfunction

    task automatic send_word(input logic [31:0] now, input logic h, input logic c,
                             input logic typed, input touch_report_t want, input int gap);
        touch_report_t predicted;
        in_valid <= 1'b1;
        now_ms   <= now;
        head_raw <= h;
        chin_raw <= c;
        do @(posedge clk); while (in_ready !== 1'b1);
        predicted = classify_sample(now, h, c);
        expected_reports.push_back(typed ? want : predicted);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // only once the pipe has drained
    task automatic write_config(input logic [15:0] deb, input logic [15:0] tap,
                                input logic [15:0] hold, input logic chin);
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_data  <= deb;
        @(posedge clk);
        cfg_index <= REG_TAP_MAX;
        cfg_data  <= tap;
        @(posedge clk);
        cfg_index <= REG_HOLD_MIN;
        cfg_data  <= hold;
        @(posedge clk);
        cfg_index <= REG_CHIN_ENABLE;
        cfg_data  <= CFG_WIDTH'(chin);
        @(posedge clk);
        cfg_we       <= 1'b0;
        debounce_cfg = deb;
        tap_cfg      = tap;
        hold_cfg     = hold;
        chin_cfg     = chin;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        touch_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_reports.size() == 0)
            begin
                $display("%0t: result word with nothing expected", $time);
                errors++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("head_event", 32'(want.head_ev), 32'(head_event));
                check_field("chin_event", 32'(want.chin_ev), 32'(chin_event));
                check_field("head_pressed", 32'(want.head_pr), 32'(head_pressed));
                check_field("chin_pressed", 32'(want.chin_pr), 32'(chin_pressed));
                check_field("head_held", 32'(want.head_hd), 32'(head_held));
                check_field("chin_held", 32'(want.chin_hd), 32'(chin_held));
                check_field("head_hold_time", want.head_t, head_hold_time);
                check_field("chin_hold_time", want.chin_t, chin_hold_time);
            end
        end
    end

    initial
    begin : result_sink
        int  stall;
        int  pick;
        bit  long_done;
        long_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (!long_done && results_seen >= 300)
            begin
                long_done = 1'b1;
                stall     = LONG_STALL;
            end
            else if (pick < 50)
                stall = 0;
            else if (pick < 85)
                stall = $urandom_range(1, 3);
            else if (pick < 98)
                stall = $urandom_range(4, 15);
            else
                stall = $urandom_range(30, 120);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, (pick % 10 == 0) ? 60 : 8)) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d words still expected", $time, expected_reports.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        sample_row_t row;
        logic [31:0] t;
        logic        head_tgt;
        logic        chin_tgt;
        logic        h;
        logic        c;
        bit          steady;
        int          pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
        begin
            row = DIRECTED_ROWS[i];
            if (row.cfg)
                write_config(row.deb, row.tap, row.hold, row.chin_en);
            send_word(row.now, row.head, row.chin, row.typed, row.want, next_gap(1'b0));
        end

        // touch episodes scaled to the current limits, with bounce and odd jumps
        t        = 32'h0000_1000;
        head_tgt = 1'b0;
        chin_tgt = 1'b0;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_config(pick_limit(200), pick_limit(1000), pick_limit(3000),
                         $urandom_range(0, 3) != 0);
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    t = $urandom;
                else if (pick < 45)
                    t += $urandom_range(0, debounce_cfg / 2 + tap_cfg / 4 + 8);
                else if (pick < 88)
                    t += $urandom_range(0, hold_cfg / 4 + debounce_cfg + 16);
                else
                    t += $urandom_range(hold_cfg / 2, hold_cfg + debounce_cfg + 100);
                if ($urandom_range(0, 7) == 0)
                    head_tgt = !head_tgt;
                if ($urandom_range(0, 7) == 0)
                    chin_tgt = !chin_tgt;
                if (pick < 3)
                begin
                    h = 1'($urandom_range(0, 1));
                    c = 1'($urandom_range(0, 1));
                end
                else
                begin
                    h = head_tgt ^ ($urandom_range(0, 11) == 0);
                    c = chin_tgt ^ ($urandom_range(0, 11) == 0);
                end
                send_word(t, h, c, 1'b0, '0, next_gap(steady));
            end
        end

        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
